@@ rtl/bmmre_pkg.sv @@
// Shared types and constants for the min/max/RMS envelope block.
// Used by bmmre_ctrl, bmmre_dpath and the top level.
package bmmre_pkg;

    localparam int CFG_W = 16;
    localparam logic [CFG_W-1:0] BLOCK_LEN_RESET = 16'd1024;

    typedef struct packed {
        logic load;
        logic acc_sq;
        logic acc_sum;
        logic div_init;
        logic div_step;
        logic sqrt_init;
        logic sqrt_step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic block_done;
        logic div_last;
        logic sqrt_last;
        logic out_free;
    } t_dp_sts;

endpackage

@@ rtl/bmmre_ctrl.sv @@
// Sequencer for the envelope block: accumulate, divide, square root, emit.
// Depends on bmmre_pkg for the command and status structs.
module bmmre_ctrl
    import bmmre_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_SUM,
        S_DIV_INIT,
        S_DIV,
        S_SQRT_INIT,
        S_SQRT,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.acc_sq = 1'b1;
                n_state      = S_SUM;
            end
            S_SUM: begin
                o_cmd.acc_sum = 1'b1;
                n_state       = i_sts.block_done ? S_DIV_INIT : S_IDLE;
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_SQRT_INIT;
            end
            S_SQRT_INIT: begin
                o_cmd.sqrt_init = 1'b1;
                n_state         = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_sts.sqrt_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

@@ rtl/bmmre_dpath.sv @@
// Datapath: min/max, saturating square sum, restoring divider, bit-pair isqrt,
// output register. Depends on bmmre_pkg; driven by bmmre_ctrl.
module bmmre_dpath
    import bmmre_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    output t_dp_sts                       o_sts,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_cfg_wr_en,
    input  logic [CFG_W-1:0]              i_cfg_wr_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_block_min,
    output logic signed [SAMPLE_BITS-1:0] o_block_max,
    output logic [SAMPLE_BITS-1:0]        o_block_rms
);

    localparam int S       = SAMPLE_BITS;
    localparam int C       = COUNT_BITS;
    localparam int SUM_RAW = 2 * S - 2 + C;
    localparam int SUM_W   = (SUM_RAW > 64) ? 64 : SUM_RAW;
    localparam int QW      = SUM_W + (SUM_W % 2);
    localparam int RW      = QW / 2;
    localparam int STEP_W  = $clog2(SUM_W);
    localparam int CMP_W   = (C > CFG_W) ? C : CFG_W;

    localparam logic signed [S-1:0] SMP_MAX = {1'b0, {(S-1){1'b1}}};
    localparam logic signed [S-1:0] SMP_MIN = {1'b1, {(S-1){1'b0}}};
    localparam logic [C-1:0]        CNT_MAX = {C{1'b1}};

    logic [CFG_W-1:0]        r_block_len;
    logic signed [S-1:0]     r_sample;
    logic signed [S-1:0]     r_min;
    logic signed [S-1:0]     r_max;
    logic [2*S-1:0]          r_sq;
    logic [SUM_W-1:0]        r_sum;
    logic [C-1:0]            r_count;
    logic [SUM_W-1:0]        r_quo;
    logic [C-1:0]            r_rem;
    logic [QW-1:0]           r_rad;
    logic [RW-1:0]           r_root;
    logic [RW:0]             r_srem;
    logic [STEP_W-1:0]       r_step;
    logic                    r_out_valid;
    logic signed [S-1:0]     r_out_min;
    logic signed [S-1:0]     r_out_max;
    logic [S-1:0]            r_out_rms;

    logic [S-1:0]            mag;
    logic [SUM_W:0]          sum_ext;
    logic [CMP_W-1:0]        len_ext;
    logic [CMP_W-1:0]        len_eff;
    logic [C:0]              rem_sh;
    logic [C:0]              rem_diff;
    logic                    q_bit;
    logic [RW+2:0]           srem_sh;
    logic [RW+2:0]           trial;
    logic [RW+2:0]           srem_diff;
    logic                    r_bit;

    assign mag     = r_sample[S-1] ? (~r_sample + 1'b1) : r_sample;
    assign sum_ext = {1'b0, r_sum} + (SUM_W+1)'(r_sq);

    always_comb begin
        len_ext = CMP_W'(r_block_len);
        if (len_ext == '0) begin
            len_eff = CMP_W'(1);
        end else if (len_ext > CMP_W'(CNT_MAX)) begin
            len_eff = CMP_W'(CNT_MAX);
        end else begin
            len_eff = len_ext;
        end
    end

    assign rem_sh   = {r_rem, r_quo[SUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_count};
    assign q_bit    = (rem_sh >= {1'b0, r_count});

    assign srem_sh   = {r_srem, r_rad[QW-1:QW-2]};
    assign trial     = (RW+3)'({r_root, 2'b01});
    assign srem_diff = srem_sh - trial;
    assign r_bit     = (srem_sh >= trial);

    assign o_sts.block_done = (CMP_W'(r_count) >= len_eff);
    assign o_sts.div_last   = (r_step == STEP_W'(SUM_W - 1));
    assign o_sts.sqrt_last  = (r_step == STEP_W'(RW - 1));
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_len <= BLOCK_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_block_len <= i_cfg_wr_data;
        end
    end

    // block accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min   <= SMP_MAX;
            r_max   <= SMP_MIN;
            r_sum   <= '0;
            r_count <= '0;
        end else if (i_cmd.finish) begin
            r_min   <= SMP_MAX;
            r_max   <= SMP_MIN;
            r_sum   <= '0;
            r_count <= '0;
        end else if (i_cmd.acc_sq) begin
            if (r_sample < r_min) r_min <= r_sample;
            if (r_sample > r_max) r_max <= r_sample;
            if (r_count != CNT_MAX) r_count <= r_count + 1'b1;
        end else if (i_cmd.acc_sum) begin
            r_sum <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_sample <= i_sample;
        if (i_cmd.acc_sq) r_sq <= mag * mag;
    end

    // divide, then square root; shared step counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_quo  <= r_sum;
            r_rem  <= '0;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_quo  <= {r_quo[SUM_W-2:0], q_bit};
            r_rem  <= q_bit ? rem_diff[C-1:0] : rem_sh[C-1:0];
            r_step <= r_step + 1'b1;
        end else if (i_cmd.sqrt_init) begin
            r_rad  <= QW'(r_quo);
            r_root <= '0;
            r_srem <= '0;
            r_step <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rad  <= {r_rad[QW-3:0], 2'b00};
            r_root <= {r_root[RW-2:0], r_bit};
            r_srem <= r_bit ? srem_diff[RW:0] : srem_sh[RW:0];
            r_step <= r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_min <= r_min;
            r_out_max <= r_max;
            r_out_rms <= r_root[S-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_block_min = r_out_min;
    assign o_block_max = r_out_max;
    assign o_block_rms = r_out_rms;

endmodule

@@ rtl/block_min_max_rms_envelope.sv @@
// Block min/max/RMS envelope decimator: top level.
// Instantiates bmmre_ctrl and bmmre_dpath; depends on bmmre_pkg.
//
// Input channel: i_in_valid / o_in_stall carry one signed sample word.
// Output channel: o_out_valid / i_out_stall carry min, max and RMS of a
// finished block. A word moves when valid is high and stall is low.
// i_cfg_wr_en / i_cfg_wr_data write the block length (0 acts as 1,
// values above the counter range saturate). Write only while idle.
// Each sample runs load, square and sum steps. The sample that ends a block
// then runs a restoring divide (one quotient bit per step) and a bit-pair
// square root on one shared step counter; the sum is SUM_W =
// 2*SAMPLE_BITS-2+COUNT_BITS bits wide, capped at 64.
// Synchronous active-low reset sets block length to 1024, clears the
// accumulators and drops o_out_valid. A result waits in the output
// register while i_out_stall is high; samples are still taken, but the
// next finished block holds in its final step until that register frees.
module block_min_max_rms_envelope
    import bmmre_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_cfg_wr_en,
    input  logic [CFG_W-1:0]              i_cfg_wr_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_block_min,
    output logic signed [SAMPLE_BITS-1:0] o_block_max,
    output logic [SAMPLE_BITS-1:0]        o_block_rms
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    bmmre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bmmre_dpath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_sample      (i_sample),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_block_min   (o_block_min),
        .o_block_max   (o_block_max),
        .o_block_rms   (o_block_rms)
    );

endmodule

@@ sim/block_min_max_rms_envelope_tb.sv @@
// Self-checking testbench for block_min_max_rms_envelope: directed and random samples,
// block length changes between phases, results checked against a behavioral envelope tracker.
// Depends on bmmre_pkg and the block RTL.
module block_min_max_rms_envelope_tb;
    import bmmre_pkg::*;

    localparam int SAMPLE_BITS    = 16;
    localparam int COUNT_BITS     = 16;
    localparam int SETTLE_CYCLES  = 120;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_SAMPLES = 430;

    typedef enum logic [1:0] {STIM_SAMPLE, STIM_SET_LENGTH, STIM_PAUSE} t_stim_kind;

    typedef struct packed {
        t_stim_kind  kind;
        logic [15:0] value;
    } t_stim_word;

    typedef struct packed {
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        logic [15:0]        rms;
    } t_envelope;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_in_valid    = 1'b0;
    logic signed [SAMPLE_BITS-1:0] i_sample      = '0;
    logic                          i_cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]              i_cfg_wr_data = '0;
    logic                          i_out_stall   = 1'b0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    logic signed [SAMPLE_BITS-1:0] o_block_min;
    logic signed [SAMPLE_BITS-1:0] o_block_max;
    logic [SAMPLE_BITS-1:0]        o_block_rms;

    t_stim_word stim_q[$];
    t_envelope  envelope_q[$];

    // running envelope of the current block
    logic signed [15:0] trk_min;
    logic signed [15:0] trk_max;
    logic [63:0]        trk_sq_sum;
    logic [15:0]        trk_count;
    logic [15:0]        trk_len;

    int       idle_cycles     = 0;
    int       mismatch_count  = 0;
    int       results_seen    = 0;
    bit       sample_taken    = 1'b0;
    int       burst_left      = 1;
    int       gap_left        = 0;
    int       stall_mode      = 0;
    int       stall_mode_left = 0;
    int       hold_left       = 0;
    bit [1:0] hold_done       = '0;

    block_min_max_rms_envelope #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample     (i_sample),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_block_min  (o_block_min),
        .o_block_max  (o_block_max),
        .o_block_rms  (o_block_rms)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    task automatic clear_block_track();
        trk_min    = 16'sh7FFF;
        trk_max    = -16'sh8000;
        trk_sq_sum = '0;
        trk_count  = '0;
    endtask

    task automatic track_sample(input logic signed [15:0] s);
        logic signed [31:0] wide;
        logic [63:0]        sq;
        logic [15:0]        len;
        t_envelope          done;
        wide = s;
        if (s < trk_min) trk_min = s;
        if (s > trk_max) trk_max = s;
        if (wide < 0) wide = -wide;
        sq = 64'(wide) * 64'(wide);
        if (trk_sq_sum > ~64'd0 - sq) trk_sq_sum = ~64'd0;
        else trk_sq_sum = trk_sq_sum + sq;
        if (trk_count != 16'hFFFF) trk_count = trk_count + 16'd1;
        len = (trk_len == 16'd0) ? 16'd1 : trk_len;
        if (trk_count >= len) begin
            done.lo  = trk_min;
            done.hi  = trk_max;
            done.rms = 16'(root_floor(trk_sq_sum / 64'(trk_count)));
            envelope_q.insert(envelope_q.size(), done);
            clear_block_track();
        end
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 32) - 16);
            3: return {1'b1, 15'($urandom_range(0, 15))};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_word(input t_stim_kind kind, input logic [15:0] value);
        t_stim_word w;
        w.kind  = kind;
        w.value = value;
        stim_q.insert(stim_q.size(), w);
    endtask

    // sample driver: bursts with random gaps, length writes only when the block is idle
    always @(negedge i_clk) begin : sample_drive
        t_stim_word  head;
        logic        nxt_valid;
        logic        nxt_wr_en;
        logic [15:0] nxt_sample;
        logic [15:0] nxt_wr_data;
        nxt_valid   = 1'b0;
        nxt_wr_en   = 1'b0;
        nxt_sample  = i_sample;
        nxt_wr_data = i_cfg_wr_data;
        if (i_rst_n) begin
            if (i_in_valid && !sample_taken) begin
                nxt_valid = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (stim_q.size() != 0) begin
                head = stim_q[0];
                case (head.kind)
                    STIM_SAMPLE: begin
                        void'(stim_q.pop_front());
                        nxt_valid  = 1'b1;
                        nxt_sample = head.value;
                        burst_left--;
                        if (burst_left <= 0) begin
                            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                                     : $urandom_range(1, 8);
                            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                        end
                    end
                    STIM_SET_LENGTH: begin
                        if (envelope_q.size() == 0 && idle_cycles >= SETTLE_CYCLES) begin
                            void'(stim_q.pop_front());
                            nxt_wr_en   = 1'b1;
                            nxt_wr_data = head.value;
                        end
                    end
                    default: begin
                        if (envelope_q.size() == 0) void'(stim_q.pop_front());
                    end
                endcase
            end
        end
        i_in_valid    <= nxt_valid;
        i_sample      <= nxt_sample;
        i_cfg_wr_en   <= nxt_wr_en;
        i_cfg_wr_data <= nxt_wr_data;
    end

    // result side stall pattern, with two long hold-offs
    always @(negedge i_clk) begin : stall_drive
        logic nxt_stall;
        nxt_stall = 1'b0;
        if (i_rst_n) begin
            if (!hold_done[0] && results_seen >= 25) begin
                hold_done[0] = 1'b1;
                hold_left    = HOLD_CYCLES;
            end
            if (!hold_done[1] && results_seen >= 60) begin
                hold_done[1] = 1'b1;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                nxt_stall = 1'b1;
            end else begin
                if (stall_mode_left == 0) begin
                    stall_mode      = $urandom_range(0, 2);
                    stall_mode_left = $urandom_range(20, 80);
                end
                stall_mode_left--;
                case (stall_mode)
                    0: nxt_stall = 1'b0;
                    1: nxt_stall = 1'($urandom_range(0, 1));
                    default: nxt_stall = ($urandom_range(0, 3) != 0);
                endcase
            end
        end
        i_out_stall <= nxt_stall;
    end

    always @(posedge i_clk) begin : result_check
        t_envelope exp_env;
        sample_taken = 1'b0;
        if (!i_rst_n) begin
            trk_len = BLOCK_LEN_RESET;
            clear_block_track();
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (i_cfg_wr_en) begin
                trk_len     = i_cfg_wr_data;
                idle_cycles = 0;
            end
            if (o_out_valid && !i_out_stall) begin
                idle_cycles = 0;
                results_seen++;
                if (envelope_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word: min %0d max %0d rms %0d",
                                 o_block_min, o_block_max, o_block_rms);
                end else begin
                    exp_env = envelope_q.pop_front();
                    if (o_block_min !== exp_env.lo || o_block_max !== exp_env.hi ||
                        o_block_rms !== exp_env.rms) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $write("result %0d: expected min %0d max %0d rms %0d, ",
                                   results_seen, exp_env.lo, exp_env.hi, exp_env.rms);
                            $display("got min %0d max %0d rms %0d",
                                     o_block_min, o_block_max, o_block_rms);
                        end
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                idle_cycles  = 0;
                sample_taken = 1'b1;
                track_sample(i_sample);
            end
        end
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int          total;
        int          len;
        int          eff;
        int          blocks;
        int          n;
        int          pause_at;
        bit          constant_block;
        bit          paused;
        logic [15:0] level;

        // partial block at the reset length, then lowered below the count
        queue_word(STIM_SAMPLE, 16'h7FFF);
        queue_word(STIM_SAMPLE, 16'h8000);
        queue_word(STIM_SAMPLE, 16'h0000);
        queue_word(STIM_SAMPLE, 16'hFFFF);
        queue_word(STIM_SAMPLE, 16'h0001);
        queue_word(STIM_SET_LENGTH, 16'd3);
        queue_word(STIM_SAMPLE, 16'h1234);
        // zero length acts as one
        queue_word(STIM_SET_LENGTH, 16'd0);
        queue_word(STIM_SAMPLE, 16'h8000);
        queue_word(STIM_SAMPLE, 16'h7FFF);
        queue_word(STIM_SAMPLE, 16'h0000);
        queue_word(STIM_SAMPLE, 16'hFFFF);
        queue_word(STIM_SAMPLE, 16'h0001);
        queue_word(STIM_SET_LENGTH, 16'd1);
        queue_word(STIM_SAMPLE, 16'h5555);
        queue_word(STIM_SAMPLE, 16'hAAAA);
        queue_word(STIM_SET_LENGTH, 16'd2);
        queue_word(STIM_SAMPLE, 16'h8000);
        queue_word(STIM_SAMPLE, 16'h8000);
        queue_word(STIM_SAMPLE, 16'h7FFF);
        queue_word(STIM_SAMPLE, 16'h7FFF);
        queue_word(STIM_SAMPLE, 16'h0000);
        queue_word(STIM_SAMPLE, 16'h0000);
        queue_word(STIM_SAMPLE, 16'h8000);
        queue_word(STIM_SAMPLE, 16'h7FFF);
        // longest length, then lowered mid-block
        queue_word(STIM_SET_LENGTH, 16'hFFFF);
        for (int i = 0; i < 4; i++) queue_word(STIM_SAMPLE, pick_sample());
        queue_word(STIM_SET_LENGTH, 16'd4);
        queue_word(STIM_SAMPLE, 16'hC000);
        queue_word(STIM_PAUSE, 16'd0);

        total  = 0;
        paused = 1'b0;
        while (total < RANDOM_SAMPLES) begin
            case ($urandom_range(0, 9))
                0: len = 0;
                1: len = 1;
                2: len = 2;
                3, 4, 5: len = $urandom_range(3, 8);
                6: len = $urandom_range(9, 24);
                7, 8: len = $urandom_range(1, 4);
                default: len = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(5, 12);
            endcase
            eff    = (len == 0) ? 1 : len;
            blocks = (eff > 16) ? $urandom_range(1, 2) : $urandom_range(1, 6);
            n      = eff * blocks;
            if (eff > 1 && $urandom_range(0, 3) == 0) n = n + $urandom_range(1, eff - 1);
            pause_at       = (!paused && total >= 200) ? n / 2 : -1;
            constant_block = ($urandom_range(0, 5) == 0);
            level          = pick_sample();
            queue_word(STIM_SET_LENGTH, 16'(len));
            for (int i = 0; i < n; i++) begin
                if (i == pause_at) begin
                    queue_word(STIM_PAUSE, 16'd0);
                    paused = 1'b1;
                end
                queue_word(STIM_SAMPLE, constant_block ? level : pick_sample());
            end
            total = total + n;
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || i_in_valid || i_cfg_wr_en || envelope_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && envelope_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/bmmre_pkg.sv
rtl/bmmre_ctrl.sv
rtl/bmmre_dpath.sv
rtl/block_min_max_rms_envelope.sv
sim/block_min_max_rms_envelope_tb.sv
